// ----- design/stereo_comb_reverb_defines.svh -----
// Assertion macros shared by the stereo comb reverb checker.
`ifndef STEREO_COMB_REVERB_DEFINES_SVH
`define STEREO_COMB_REVERB_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCR_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Implication whose consequent is checked later, disabled while reset is asserted.
`define SCR_ASSERT_TWO(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ----- design/scr_pkg.sv -----
// Shared constants, types and helpers of the stereo comb reverb.
`default_nettype none

package scr_pkg;

    localparam int LINE_DEPTH   = 4096;
    localparam int SAMPLE_WIDTH = 16;
    localparam int NUM_COMBS    = 4;
    localparam int LINE_W       = 24;
    localparam int DELAY_W      = 12;
    localparam int GAIN_W       = 15;
    localparam int MIX_W        = 16;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int MIN_DELAY    = 64;
    localparam int UNITY_Q15    = 32768;
    localparam int Q15_FRAC     = 15;

    localparam int PTR_W  = $clog2(LINE_DEPTH);
    localparam int CALC_W = ((PTR_W > DELAY_W) ? PTR_W : DELAY_W) + 1;
    localparam int COMB_SHIFT = $clog2(NUM_COMBS);
    localparam int WET_W  = LINE_W + COMB_SHIFT;
    localparam int MIX_SHIFT = Q15_FRAC + COMB_SHIFT;
    localparam int WET_PROD_W = WET_W + MIX_W + 1;
    localparam int DRY_PROD_W = SAMPLE_WIDTH + MIX_W + 1 + COMB_SHIFT;
    localparam int ACC_W = ((WET_PROD_W > DRY_PROD_W) ? WET_PROD_W : DRY_PROD_W) + 1;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic signed [LINE_W-1:0] line_t;
    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [WET_W-1:0] wet_t;

    typedef struct packed {
        logic en;
        ptr_t addr;
        logic fill;
    } rd_req_t;

    typedef struct packed {
        logic en;
        ptr_t addr;
    } wr_req_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DELAY_0 = 4'd0,
        REG_DELAY_1 = 4'd1,
        REG_DELAY_2 = 4'd2,
        REG_DELAY_3 = 4'd3,
        REG_GAIN_0  = 4'd4,
        REG_GAIN_1  = 4'd5,
        REG_GAIN_2  = 4'd6,
        REG_GAIN_3  = 4'd7
    } reg_index_t;

    localparam logic [DELAY_W-1:0] DELAY_RESET [NUM_COMBS] = '{
        12'd1425, 12'd1780, 12'd1982, 12'd2097
    };
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd26214;

    // Limit a programmed delay to the usable span of a line.
    function automatic logic [DELAY_W-1:0] clamp_delay(input logic [DELAY_W-1:0] d);
        logic [DELAY_W-1:0] r;
        r = d;
        if (int'(d) < MIN_DELAY) begin
            r = DELAY_W'(MIN_DELAY);
        end else if (int'(d) > LINE_DEPTH - 1) begin
            r = DELAY_W'(LINE_DEPTH - 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/scr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module scr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/scr_comb_line.sv -----
// One feedback comb line: delay memory, fill masking and feedback update.
`default_nettype none

module scr_comb_line import scr_pkg::*; (
    input  logic              aclk,
    input  rd_req_t           rd_req,
    input  wr_req_t           wr_req,
    input  sample_t           x,
    input  logic [GAIN_W-1:0] gain,
    output line_t             delayed
);

    localparam int PROD_W = LINE_W + GAIN_W + 1;
    localparam int SUM_W  = LINE_W + 2;
    localparam logic signed [SUM_W-1:0] LINE_HI = SUM_W'((1 <<< (LINE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] LINE_LO = -LINE_HI - SUM_W'(1);

    logic                     fill_reg;
    logic [LINE_W-1:0]        rd_data;
    logic signed [PROD_W-1:0] prod;
    logic signed [LINE_W:0]   scaled;
    logic signed [SUM_W-1:0]  sum;
    line_t                    stored;

    scr_ram #(
        .WIDTH(LINE_W),
        .DEPTH(LINE_DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_req.en),
        .wr_addr(wr_req.addr),
        .wr_data(stored),
        .rd_en  (rd_req.en),
        .rd_addr(rd_req.addr),
        .rd_data(rd_data)
    );

    // Track whether the entry just read has been written since reset.
    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            fill_reg <= rd_req.fill;
        end
    end

    assign delayed = fill_reg ? $signed(rd_data) : '0;

    always_comb begin
        prod   = delayed * $signed({1'b0, gain});
        scaled = $signed(prod[PROD_W-1:GAIN_W]);
        sum    = SUM_W'(x) + SUM_W'(scaled);
        if (sum > LINE_HI) begin
            stored = LINE_HI[LINE_W-1:0];
        end else if (sum < LINE_LO) begin
            stored = LINE_LO[LINE_W-1:0];
        end else begin
            stored = sum[LINE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- design/scr_mix.sv -----
// Wet/dry mixer for one channel with floor scaling and output saturation.
`default_nettype none

module scr_mix import scr_pkg::*; (
    input  sample_t          dry,
    input  wet_t             wet_sum,
    input  logic [MIX_W-1:0] mix,
    output sample_t          mixed
);

    localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'((1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_LO = -OUT_HI - ACC_W'(1);

    logic [MIX_W-1:0]        mix_sat;
    logic [MIX_W-1:0]        mix_inv;
    logic signed [ACC_W-1:0] dry_term;
    logic signed [ACC_W-1:0] wet_term;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] scaled;

    always_comb begin
        // Hold the wet share at unity at most.
        mix_sat  = (int'(mix) > UNITY_Q15) ? MIX_W'(UNITY_Q15) : mix;
        mix_inv  = MIX_W'(UNITY_Q15) - mix_sat;
        dry_term = dry * $signed({1'b0, mix_inv});
        wet_term = wet_sum * $signed({1'b0, mix_sat});
        acc      = (dry_term <<< COMB_SHIFT) + wet_term;
        scaled   = acc >>> MIX_SHIFT;
        if (scaled > OUT_HI) begin
            mixed = OUT_HI[SAMPLE_WIDTH-1:0];
        end else if (scaled < OUT_LO) begin
            mixed = OUT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            mixed = scaled[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- design/stereo_comb_reverb.sv -----
// A result is valid once its input pair has passed the input stage and then the result register.
// Throughput: one stereo pair per cycle while the output keeps up, bounded by one read and one write per line memory.
// Reset is synchronous, active low; registers return to their reset values.
// Line contents read as zero after reset through write-pointer fill tracking: there is
// no clearing pass, and input is accepted from the first cycle after reset.
`default_nettype none

module stereo_comb_reverb import scr_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sample_t                s_in_left,
    input  sample_t                s_in_right,
    input  logic [MIX_W-1:0]       s_wet_mix,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output sample_t                m_out_left,
    output sample_t                m_out_right,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers.
    logic [DELAY_W-1:0] delay_reg [NUM_COMBS];
    logic [GAIN_W-1:0]  gain_reg  [NUM_COMBS];

    // Shared write pointer and the flag that marks the lines as fully written once.
    ptr_t wp_reg;
    ptr_t wp_next;
    logic wrapped_reg;

    // Input stage: the accepted pair waits here while the line memories return data.
    logic             s1_valid_reg;
    sample_t          s1_left_reg;
    sample_t          s1_right_reg;
    logic [MIX_W-1:0] s1_mix_reg;
    ptr_t             s1_wp_reg;

    // Result register.
    logic    out_valid_reg;
    sample_t out_left_reg;
    sample_t out_right_reg;

    logic    accept;
    logic    s1_advance;
    rd_req_t rd_req [NUM_COMBS];
    wr_req_t wr_req;
    line_t   delayed_left  [NUM_COMBS];
    line_t   delayed_right [NUM_COMBS];
    wet_t    wet_left;
    wet_t    wet_right;
    sample_t mixed_left;
    sample_t mixed_right;

    // Handshake: the input stage moves on whenever the result register is free or
    // being drained, so a new pair is taken in every cycle the output keeps up.
    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign accept     = s_valid && s_ready;

    assign m_valid     = out_valid_reg;
    assign m_out_left  = out_left_reg;
    assign m_out_right = out_right_reg;

    // Configuration writes; indexes beyond the register list drop silently.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_COMBS; k++) begin
                delay_reg[k] <= DELAY_RESET[k];
                gain_reg[k]  <= GAIN_RESET;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DELAY_0: delay_reg[0] <= cfg_data[DELAY_W-1:0];
                REG_DELAY_1: delay_reg[1] <= cfg_data[DELAY_W-1:0];
                REG_DELAY_2: delay_reg[2] <= cfg_data[DELAY_W-1:0];
                REG_DELAY_3: delay_reg[3] <= cfg_data[DELAY_W-1:0];
                REG_GAIN_0:  gain_reg[0]  <= cfg_data[GAIN_W-1:0];
                REG_GAIN_1:  gain_reg[1]  <= cfg_data[GAIN_W-1:0];
                REG_GAIN_2:  gain_reg[2]  <= cfg_data[GAIN_W-1:0];
                REG_GAIN_3:  gain_reg[3]  <= cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance the write pointer once per accepted pair, wrapping at the line depth.
    assign wp_next = (wp_reg == PTR_W'(LINE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else if (accept) begin
            wp_reg <= wp_next;
            if (wp_reg == PTR_W'(LINE_DEPTH - 1)) begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    // Read addresses trail the write pointer by each comb's delay. An address reached
    // without wrapping below zero lies behind the pointer and was written this pass;
    // one that wraps is valid only after the pointer has gone round once.
    always_comb begin
        logic [DELAY_W-1:0] d;
        logic [CALC_W-1:0]  wp_ext;
        logic [CALC_W-1:0]  d_ext;
        logic [CALC_W-1:0]  rd_full;
        for (int k = 0; k < NUM_COMBS; k++) begin
            d      = clamp_delay(delay_reg[k]);
            wp_ext = CALC_W'(wp_reg);
            d_ext  = CALC_W'(d);
            rd_req[k].en = accept;
            if (wp_ext >= d_ext) begin
                rd_full        = wp_ext - d_ext;
                rd_req[k].fill = 1'b1;
            end else begin
                rd_full        = wp_ext + CALC_W'(LINE_DEPTH) - d_ext;
                rd_req[k].fill = wrapped_reg;
            end
            rd_req[k].addr = rd_full[PTR_W-1:0];
        end
    end

    // Write back the feedback values when the input stage hands its pair on.
    assign wr_req.en   = s1_advance;
    assign wr_req.addr = s1_wp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_left_reg  <= s_in_left;
            s1_right_reg <= s_in_right;
            s1_mix_reg   <= s_wet_mix;
            s1_wp_reg    <= wp_reg;
        end
    end

    // Four comb lines per channel, all sharing one write pointer; left and right lines share each comb's read address.
    for (genvar k = 0; k < NUM_COMBS; k++) begin : g_comb
        scr_comb_line u_left (
            .aclk   (aclk),
            .rd_req (rd_req[k]),
            .wr_req (wr_req),
            .x      (s1_left_reg),
            .gain   (gain_reg[k]),
            .delayed(delayed_left[k])
        );

        scr_comb_line u_right (
            .aclk   (aclk),
            .rd_req (rd_req[k]),
            .wr_req (wr_req),
            .x      (s1_right_reg),
            .gain   (gain_reg[k]),
            .delayed(delayed_right[k])
        );
    end

    // Wet signal kept as the plain sum; the mixer folds in the divide by four.
    always_comb begin
        wet_left  = '0;
        wet_right = '0;
        for (int k = 0; k < NUM_COMBS; k++) begin
            wet_left  = wet_left  + WET_W'(delayed_left[k]);
            wet_right = wet_right + WET_W'(delayed_right[k]);
        end
    end

    scr_mix u_mix_left (
        .dry    (s1_left_reg),
        .wet_sum(wet_left),
        .mix    (s1_mix_reg),
        .mixed  (mixed_left)
    );

    scr_mix u_mix_right (
        .dry    (s1_right_reg),
        .wet_sum(wet_right),
        .mix    (s1_mix_reg),
        .mixed  (mixed_right)
    );

    // Result register: load on advance, drop valid once the transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            out_left_reg  <= mixed_left;
            out_right_reg <= mixed_right;
        end
    end

endmodule

`default_nettype wire

// ----- design/stereo_comb_reverb_checker.sv -----
// Port-level checker for the stereo comb reverb and its bind statement.
`default_nettype none
`include "stereo_comb_reverb_defines.svh"

module stereo_comb_reverb_checker import scr_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input sample_t                m_out_left,
    input sample_t                m_out_right
);

    // Hold a stalled result.
    `SCR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_left) && $stable(m_out_right), "stalled result changed")

    // An empty result register never blocks the input.
    `SCR_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "input stalled with empty output")

    // Every input transfer is followed by a valid result once it has passed the input stage.
    `SCR_ASSERT_TWO(a_latency, aclk, aresetn, s_valid && s_ready, m_valid, "result missing after transfer")

    // A result appears only for an earlier transfer that has come through the input stage.
    `SCR_ASSERT_IMPL(a_no_invented, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready, 2), "result without transfer")

endmodule

bind stereo_comb_reverb stereo_comb_reverb_checker u_checker (.*);

`default_nettype wire

// ----- sim/stereo_comb_reverb_test.sv -----
// Self-checking testbench for the stereo comb reverb: predicts every mixed output pair.
`default_nettype none

module stereo_comb_reverb_test import scr_pkg::*; ();

    localparam int HALF_PERIOD  = 5;
    localparam int STALL_LIMIT  = 2000;   // cycles without any transfer before giving up
    localparam int SETTLE       = 8;      // cycles to linger once nothing is outstanding
    localparam int RANDOM_ITEMS = 200;    // random pairs per random phase
    localparam int FEEDBACK_ITEMS = 480;  // several passes of a short loop at full feedback

    localparam int MAX_DELAY = (1 << DELAY_W) - 1;
    localparam int MAX_GAIN  = (1 << GAIN_W) - 1;

    // First register index with no register behind it; it and everything above are ignored.
    localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_REG = CFG_INDEX_W'(REG_GAIN_3 + 1);

    typedef struct {
        sample_t left;
        sample_t right;
    } stereo_t;

    // Shadow of the comb lines and registers; turns each input transfer into the
    // output pair the block must produce, and checks outputs in order.
    class reverb_scoreboard;
        line_t            left_line  [NUM_COMBS][LINE_DEPTH];
        line_t            right_line [NUM_COMBS][LINE_DEPTH];
        ptr_t             write_ptr;
        logic [DELAY_W-1:0] delay [NUM_COMBS];
        logic [GAIN_W-1:0]  gain  [NUM_COMBS];
        stereo_t          pending_mix [$];
        int               mismatches;

        function new();
            for (int k = 0; k < NUM_COMBS; k++) begin
                for (int i = 0; i < LINE_DEPTH; i++) begin
                    left_line[k][i]  = '0;
                    right_line[k][i] = '0;
                end
                delay[k] = DELAY_RESET[k];
                gain[k]  = GAIN_RESET;
            end
            write_ptr  = '0;
            mismatches = 0;
        endfunction

        function longint clip(longint x, int w);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (x > hi) return hi;
            if (x < lo) return lo;
            return x;
        endfunction

        function void apply_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx <= REG_DELAY_3) begin
                delay[idx - REG_DELAY_0] = value[DELAY_W-1:0];
            end else if (idx <= REG_GAIN_3) begin
                gain[idx - REG_GAIN_0] = value[GAIN_W-1:0];
            end
        endfunction

        function void note_pair(sample_t in_l, sample_t in_r, logic [MIX_W-1:0] mix_in);
            longint      xl, xr, mix, wet_l, wet_r, dl, dr, g;
            int unsigned d;
            ptr_t        tap;
            stereo_t     want;
            xl = in_l;
            xr = in_r;
            mix = mix_in;
            if (mix > UNITY_Q15) mix = UNITY_Q15;
            wet_l = 0;
            wet_r = 0;
            for (int k = 0; k < NUM_COMBS; k++) begin
                d = delay[k];
                if (d < MIN_DELAY) d = MIN_DELAY;
                if (d > LINE_DEPTH - 1) d = LINE_DEPTH - 1;
                tap = ptr_t'(write_ptr - d);
                dl = left_line[k][tap];
                dr = right_line[k][tap];
                g  = gain[k];
                left_line[k][write_ptr]  = line_t'(clip(xl + ((dl * g) >>> Q15_FRAC), LINE_W));
                right_line[k][write_ptr] = line_t'(clip(xr + ((dr * g) >>> Q15_FRAC), LINE_W));
                wet_l += dl;
                wet_r += dr;
            end
            write_ptr = write_ptr + 1'b1;
            // wet is the sum over four taps, so the dry term carries the same factor
            want.left  = sample_t'(clip((xl * (UNITY_Q15 - mix) * NUM_COMBS + wet_l * mix)
                                        >>> MIX_SHIFT, SAMPLE_WIDTH));
            want.right = sample_t'(clip((xr * (UNITY_Q15 - mix) * NUM_COMBS + wet_r * mix)
                                        >>> MIX_SHIFT, SAMPLE_WIDTH));
            pending_mix.push_back(want);
        endfunction

        function void check_pair(sample_t got_l, sample_t got_r);
            stereo_t want;
            if (pending_mix.size() == 0) begin
                $error("output transfer with nothing pending: out_left %0d out_right %0d",
                       got_l, got_r);
                mismatches++;
                return;
            end
            want = pending_mix.pop_front();
            if (got_l !== want.left) begin
                $error("out_left: expected %0d, actual %0d", want.left, got_l);
                mismatches++;
            end
            if (got_r !== want.right) begin
                $error("out_right: expected %0d, actual %0d", want.right, got_r);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_mix.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    sample_t                s_in_left;
    sample_t                s_in_right;
    logic [MIX_W-1:0]       s_wet_mix;
    logic                   m_valid;
    logic                   m_ready;
    sample_t                m_out_left;
    sample_t                m_out_right;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    reverb_scoreboard sb;
    int               burst_left;
    int               gap_cycles;
    int               stuck_cycles;
    logic [15:0]      stall_pattern;

    stereo_comb_reverb u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_left   (s_in_left),
        .s_in_right  (s_in_right),
        .s_wet_mix   (s_wet_mix),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_left  (m_out_left),
        .m_out_right (m_out_right),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Receiver: replay a rotating 16-bit ready pattern, drawing a new one after each window.
    // Patterns range from always ready through random stalls to long back-pressure.
    initial begin
        m_ready = 1'b0;
        forever begin
            case ($urandom_range(0, 3))
                0: stall_pattern = '1;
                1: stall_pattern = 16'($urandom);
                2: stall_pattern = 16'hFF00 >> $urandom_range(0, 7);
                default: stall_pattern = 16'($urandom) | 16'($urandom);
            endcase
            stall_pattern[0] = 1'b1;   // never a whole window without ready
            repeat (64) begin
                @(negedge aclk);
                m_ready = stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // Check every output transfer; count cycles without any transfer for the watchdog.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_pair(m_out_left, m_out_right);
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one pair; hold it until the transfer. Bursts of back-to-back pairs
    // alternate with random gaps in which valid drops.
    task automatic send_pair(input sample_t in_l, input sample_t in_r,
                             input logic [MIX_W-1:0] mix);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
        burst_left--;
        @(negedge aclk);
        if (gap_cycles > 0) begin
            s_valid = 1'b0;
            repeat (gap_cycles) @(negedge aclk);
            gap_cycles = 0;
        end
        s_valid    = 1'b1;
        s_in_left  = in_l;
        s_in_right = in_r;
        s_wet_mix  = mix;
        do @(posedge aclk); while (!s_ready);
        sb.note_pair(in_l, in_r, mix);
    endtask

    // Drop valid and wait until every predicted pair has come back.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.apply_config(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Program all delays and gains with junk in the unused upper bits, plus one
    // write to an index that has no register.
    task automatic set_combs(input int unsigned dly [NUM_COMBS],
                             input int unsigned gn [NUM_COMBS]);
        logic [CFG_DATA_W-1:0] word;
        wait_idle();
        for (int k = 0; k < NUM_COMBS; k++) begin
            word = CFG_DATA_W'($urandom);
            word[DELAY_W-1:0] = dly[k][DELAY_W-1:0];
            write_reg(CFG_INDEX_W'(REG_DELAY_0 + k), word);
            word = CFG_DATA_W'($urandom);
            word[GAIN_W-1:0] = gn[k][GAIN_W-1:0];
            write_reg(CFG_INDEX_W'(REG_GAIN_0 + k), word);
        end
        write_reg(FIRST_UNUSED_REG + CFG_INDEX_W'($urandom_range(0, 7)), CFG_DATA_W'($urandom));
    endtask

    task automatic random_setting();
        int unsigned dly [NUM_COMBS];
        int unsigned gn  [NUM_COMBS];
        for (int k = 0; k < NUM_COMBS; k++) begin
            // keep most delays short so taps land on freshly written samples
            dly[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_DELAY)
                                                 : $urandom_range(0, 400);
            case ($urandom_range(0, 5))
                0: gn[k] = 0;
                1: gn[k] = MAX_GAIN;
                default: gn[k] = $urandom_range(0, MAX_GAIN);
            endcase
        end
        set_combs(dly, gn);
    endtask

    function automatic sample_t any_sample();
        case ($urandom_range(0, 7))
            0: return sample_t'(32767);
            1: return sample_t'(-32768);
            2: return '0;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [MIX_W-1:0] any_mix();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return MIX_W'(UNITY_Q15);
            2: return MIX_W'($urandom_range(UNITY_Q15 + 1, (1 << MIX_W) - 1));
            3: return MIX_W'($urandom);
            default: return MIX_W'($urandom_range(0, UNITY_Q15));
        endcase
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_pair(any_sample(), any_sample(), any_mix());
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_in_left  = '0;
        s_in_right = '0;
        s_wet_mix  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        burst_left = 0;
        gap_cycles = 0;
        stuck_cycles = 0;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings, lines still empty: sample extremes against every kind of mix,
        // including shares above unity that must clamp to wet only.
        send_pair(sample_t'(32767),  sample_t'(-32768), MIX_W'(0));
        send_pair(sample_t'(-32768), sample_t'(32767),  MIX_W'(0));
        send_pair(sample_t'(32767),  sample_t'(32767),  MIX_W'(UNITY_Q15));
        send_pair(sample_t'(-32768), sample_t'(-32768), MIX_W'(UNITY_Q15));
        send_pair(sample_t'(32767),  sample_t'(-32768), MIX_W'(UNITY_Q15 + 1));
        send_pair(sample_t'(-32768), sample_t'(32767),  MIX_W'(16'hFFFF));
        send_pair(sample_t'(-1),     sample_t'(1),      MIX_W'(1));
        send_pair(sample_t'(1),      sample_t'(-1),     MIX_W'(UNITY_Q15 - 1));
        send_pair(sample_t'(-32768), sample_t'(-1),     MIX_W'(16384));
        send_pair(sample_t'(-1),     sample_t'(32767),  MIX_W'(16383));
        send_pair(sample_t'(0),      sample_t'(0),      MIX_W'(16'h7FFF));
        send_pair(sample_t'(-3),     sample_t'(3),      MIX_W'(16'h5555));
        send_pair(sample_t'(16'h5555), sample_t'(16'hAAAA), MIX_W'(16'hAAAA));
        send_pair(sample_t'(16'hAAAA), sample_t'(16'h5555), MIX_W'(16'h5555));
        repeat (6) send_pair(any_sample(), any_sample(), any_mix());

        // Out-of-range delays clamp to the minimum; gain extremes zero and full scale.
        set_combs('{0, MIN_DELAY - 1, MIN_DELAY, 100}, '{MAX_GAIN, 0, 1, 16384});
        run_random(RANDOM_ITEMS);

        // Build up the lines: near-full-scale inputs of opposite sign on the two
        // channels with full feedback, so the wet-heavy outputs overflow both rails.
        set_combs('{MIN_DELAY, MIN_DELAY, MIN_DELAY + 1, MIN_DELAY + 2},
                  '{MAX_GAIN, MAX_GAIN, MAX_GAIN, MAX_GAIN});
        repeat (FEEDBACK_ITEMS) begin
            send_pair(sample_t'($urandom_range(32000, 32767)),
                      sample_t'(-int'($urandom_range(32000, 32768))), any_mix());
        end

        // Longest delay: the taps fall on entries not yet written since reset, so they read as zero.
        set_combs('{MAX_DELAY, MAX_DELAY, MAX_DELAY, MAX_DELAY}, '{0, 0, MAX_GAIN, 1});
        run_random(RANDOM_ITEMS);

        repeat (3) begin
            random_setting();
            run_random(RANDOM_ITEMS);
        end

        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
